FILE: rtl/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
`timescale 1ns / 1ps
`default_nettype none

package bpc_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Calibration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSURE_SENS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PRESSURE_OFFSET = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SENS_TEMPCO     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_TEMPCO   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REF_TEMP        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_COEFF      = 3'd5;

    // Temperature offset in hundredths of a degree
    localparam logic signed [18:0] TEMP_BASE = 19'sd2000;

    // Input item
    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } bpc_in_t;

    // Result item
    typedef struct packed {
        logic signed [18:0] temperature_centi;
        logic signed [31:0] pressure_centi_mbar;
        logic               result_valid;
    } bpc_out_t;

    // Calibration words
    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
    } bpc_cal_t;

    // Handoff from the temperature half to the pressure half
    typedef struct packed {
        logic               valid;
        logic               nonzero;
        logic [23:0]        d1;
        logic signed [18:0] temp;
        logic signed [34:0] off;
        logic signed [33:0] sens;
    } bpc_comp_t;

endpackage

`default_nettype wire

FILE: rtl/bpc_cal_regs.sv
// Calibration word registers behind the write port.
`timescale 1ns / 1ps
`default_nettype none

module bpc_cal_regs
    import bpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output bpc_cal_t                    cal
);

    bpc_cal_t cal_reg;
    bpc_cal_t cal_next;

    // Decode the write; unknown indexes leave everything as is
    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_PRESSURE_SENS:   cal_next.c1 = cfg_data;
                REG_PRESSURE_OFFSET: cal_next.c2 = cfg_data;
                REG_SENS_TEMPCO:     cal_next.c3 = cfg_data;
                REG_OFFSET_TEMPCO:   cal_next.c4 = cfg_data;
                REG_REF_TEMP:        cal_next.c5 = cfg_data;
                REG_TEMP_COEFF:      cal_next.c6 = cfg_data;
                default:             cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cal_reg <= '0;
        else
            cal_reg <= cal_next;
    end

    assign cal = cal_reg;

endmodule

`default_nettype wire

FILE: rtl/bpc_temp_stage.sv
// Front half: delta temperature, tempco products, TEMP, OFF and SENS.
`timescale 1ns / 1ps
`default_nettype none

module bpc_temp_stage
    import bpc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     adv,
    input  wire logic     in_valid,
    input  wire bpc_in_t  in_data,
    input  wire bpc_cal_t cal,
    output bpc_comp_t     comp
);

    // Stage 1: dT = D2 - (C5 << 8), flag for "both conversions ready"
    logic               s1_valid_reg;
    logic               s1_nonzero_reg;
    logic [23:0]        s1_d1_reg;
    logic signed [24:0] s1_dt_reg;
    logic signed [24:0] s1_dt_next;

    assign s1_dt_next = $signed({1'b0, in_data.raw_temperature})
                      - $signed({1'b0, cal.c5, 8'd0});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_nonzero_reg <= (in_data.raw_pressure != '0) && (in_data.raw_temperature != '0);
            s1_d1_reg      <= in_data.raw_pressure;
            s1_dt_reg      <= s1_dt_next;
        end
    end

    // Stage 2: three dT products against C6, C4 and C3
    logic               s2_valid_reg;
    logic               s2_nonzero_reg;
    logic [23:0]        s2_d1_reg;
    logic signed [41:0] m6_full;
    logic signed [41:0] m4_full;
    logic signed [41:0] m3_full;
    logic signed [40:0] s2_p6_reg;
    logic signed [40:0] s2_p4_reg;
    logic signed [40:0] s2_p3_reg;

    // |dT| < 2^24 and C < 2^16, so each product fits 41 signed bits
    assign m6_full = s1_dt_reg * $signed({1'b0, cal.c6});
    assign m4_full = s1_dt_reg * $signed({1'b0, cal.c4});
    assign m3_full = s1_dt_reg * $signed({1'b0, cal.c3});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_nonzero_reg <= s1_nonzero_reg;
            s2_d1_reg      <= s1_d1_reg;
            s2_p6_reg      <= $signed(m6_full[40:0]);
            s2_p4_reg      <= $signed(m4_full[40:0]);
            s2_p3_reg      <= $signed(m3_full[40:0]);
        end
    end

    // Stage 3: TEMP, OFF, SENS; shifts are arithmetic via signed part-selects
    logic signed [17:0] t_sh;
    logic signed [33:0] off_sh;
    logic signed [32:0] sens_sh;
    bpc_comp_t          s3_reg;
    bpc_comp_t          s3_next;

    assign t_sh    = $signed(s2_p6_reg[40:23]);
    assign off_sh  = $signed(s2_p4_reg[40:7]);
    assign sens_sh = $signed(s2_p3_reg[40:8]);

    always_comb
    begin
        s3_next.valid   = s2_valid_reg;
        s3_next.nonzero = s2_nonzero_reg;
        s3_next.d1      = s2_d1_reg;
        s3_next.temp    = $signed({t_sh[17], t_sh}) + TEMP_BASE;
        s3_next.off     = $signed({3'd0, cal.c2, 16'd0}) + $signed({off_sh[33], off_sh});
        s3_next.sens    = $signed({3'd0, cal.c1, 15'd0}) + $signed({sens_sh[32], sens_sh});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_reg <= '0;
        else if (adv)
            s3_reg <= s3_next;
    end

    assign comp = s3_reg;

endmodule

`default_nettype wire

FILE: rtl/bpc_press_stage.sv
// Back half: D1 * SENS in two partial products, OFF subtract, output register.
`timescale 1ns / 1ps
`default_nettype none

module bpc_press_stage
    import bpc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      adv,
    input  wire bpc_comp_t comp,
    output wire logic      out_valid,
    output bpc_out_t       out_data
);

    // Stage 4: SENS split into unsigned low 17 bits and signed high 17 bits
    logic               s4_valid_reg;
    logic               s4_nonzero_reg;
    logic signed [18:0] s4_temp_reg;
    logic signed [34:0] s4_off_reg;
    logic [40:0]        s4_pp_lo_reg;
    logic signed [40:0] s4_pp_hi_reg;
    logic [40:0]        pp_lo_next;
    logic signed [41:0] pp_hi_full;

    assign pp_lo_next = comp.d1 * comp.sens[16:0];
    assign pp_hi_full = $signed({1'b0, comp.d1}) * $signed(comp.sens[33:17]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= comp.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_nonzero_reg <= comp.nonzero;
            s4_temp_reg    <= comp.temp;
            s4_off_reg     <= comp.off;
            s4_pp_lo_reg   <= pp_lo_next;
            // |D1| < 2^24, |SENS_hi| <= 2^16: fits 41 signed bits
            s4_pp_hi_reg   <= $signed(pp_hi_full[40:0]);
        end
    end

    // Stage 5: recombine the 58-bit product and take >> 21
    logic               s5_valid_reg;
    logic               s5_nonzero_reg;
    logic signed [18:0] s5_temp_reg;
    logic signed [34:0] s5_off_reg;
    logic signed [36:0] s5_psh_reg;
    logic signed [57:0] prod_next;

    assign prod_next = $signed({s4_pp_hi_reg, 17'd0}) + $signed({17'd0, s4_pp_lo_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s5_valid_reg <= 1'b0;
        else if (adv)
            s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_nonzero_reg <= s4_nonzero_reg;
            s5_temp_reg    <= s4_temp_reg;
            s5_off_reg     <= s4_off_reg;
            s5_psh_reg     <= $signed(prod_next[57:21]);
        end
    end

    // Stage 6: subtract OFF
    logic               s6_valid_reg;
    logic               s6_nonzero_reg;
    logic signed [18:0] s6_temp_reg;
    logic signed [37:0] s6_diff_reg;
    logic signed [37:0] diff_next;

    assign diff_next = $signed({s5_psh_reg[36], s5_psh_reg})
                     - $signed({{3{s5_off_reg[34]}}, s5_off_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s6_valid_reg <= 1'b0;
        else if (adv)
            s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s6_nonzero_reg <= s5_nonzero_reg;
            s6_temp_reg    <= s5_temp_reg;
            s6_diff_reg    <= diff_next;
        end
    end

    // Stage 7: >> 15 and output register; not-ready items come out as zeros.
    // The shifted value spans only 23 signed bits, so the 32-bit clamp is a
    // plain sign extension.
    logic               out_valid_reg;
    bpc_out_t           out_reg;
    bpc_out_t           out_next;
    logic signed [22:0] p_sh;

    assign p_sh = $signed(s6_diff_reg[37:15]);

    always_comb
    begin
        if (s6_nonzero_reg)
        begin
            out_next.temperature_centi   = s6_temp_reg;
            out_next.pressure_centi_mbar = $signed({{9{p_sh[22]}}, p_sh});
            out_next.result_valid        = 1'b1;
        end
        else
        begin
            out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/baro_pressure_temp_compensation.sv
// Top level of the barometric first-order compensation pipeline.
// Accepts one raw pressure/temperature pair per cycle while in_stall is low.
// Seven register stages (input-side delta stage, three tempco multipliers,
// TEMP/OFF/SENS adders, two D1*SENS partial products, product recombine,
// OFF subtract, output register) lie between an accepted item and its
// result. The whole pipe advances as one; in_stall is high exactly while
// the output register holds an item that the receiver stalls, so empty
// slots in the pipe are not squeezed out. Calibration words are written
// through cfg_we/cfg_index/cfg_data; the user must write them only while
// no item is in flight, which the block itself does not enforce. Writes
// to indexes 6 and 7 are ignored.
`timescale 1ns / 1ps
`default_nettype none

module baro_pressure_temp_compensation
    import bpc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output wire logic                   in_stall,
    input  wire bpc_in_t                in_data,
    output wire logic                   out_valid,
    input  wire logic                   out_stall,
    output bpc_out_t                    out_data,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    bpc_cal_t  cal;
    bpc_comp_t comp;
    logic      adv;

    // Global pipeline advance
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    bpc_cal_regs u_cal_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    bpc_temp_stage u_temp_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .in_data  (in_data),
        .cal      (cal),
        .comp     (comp)
    );

    bpc_press_stage u_press_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .comp      (comp),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // Not-ready items carry all-zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.result_valid) |->
            (out_data.temperature_centi == '0) && (out_data.pressure_centi_mbar == '0))
        else $error("not-ready item with nonzero fields");

    // Pressure never leaves the 23-bit signed span of the final shift
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.pressure_centi_mbar[31:22] == 10'h000)
                    || (out_data.pressure_centi_mbar[31:22] == 10'h3FF)))
        else $error("pressure sign extension broken");

    // An empty output register never holds back the pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("stall with empty output");

endmodule

`default_nettype wire
